// ===== hdl/mbrtu_pkg.sv =====
// Shared types and constants for the Modbus RTU frame receiver.
// No dependencies; imported by mbrtu_frame_ctl and modbus_rtu_frame_receiver.
package mbrtu_pkg;

    // Receive buffer size the byte count is sized against
    localparam int unsigned BUFFER_BYTES = 256;
    localparam int unsigned COUNT_LIMIT_INT =
        (BUFFER_BYTES + 2 > 511) ? 511 : (BUFFER_BYTES + 2);
    localparam logic [8:0] COUNT_LIMIT = 9'(COUNT_LIMIT_INT);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Input operation codes
    localparam logic [1:0] FUNC_BYTE  = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_SEND  = 2'd2;
    localparam logic [1:0] FUNC_FLUSH = 2'd3;

    // Result event codes
    localparam logic [1:0] EV_GOOD     = 2'd0;
    localparam logic [1:0] EV_BAD      = 2'd1;
    localparam logic [1:0] EV_TIMEOUT  = 2'd2;
    localparam logic [1:0] EV_OVERFLOW = 2'd3;

    // Configuration register indexes
    localparam logic CFG_SILENCE = 1'b0;
    localparam logic CFG_ANSWER  = 1'b1;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] rx_byte;
        logic       need_ack;
    } in_item_t;

    typedef struct packed {
        logic [1:0] event_res;
        logic [8:0] frame_length;
    } out_item_t;

    // Result of one processed item, core to top level
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } res_t;

endpackage

// ===== hdl/mbrtu_frame_ctl.sv =====
// Receive state machine: CRC chain, byte history, frame count and timer.
// Depends on mbrtu_pkg.
module mbrtu_frame_ctl
    import mbrtu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  in_item_t    item,
    input  logic [15:0] silence_ticks,
    input  logic [15:0] answer_ticks,
    output res_t        res
);

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_ANSWER = 2'd1;
    localparam logic [1:0] MODE_FRAME  = 2'd2;

    logic [1:0]  mode_reg, mode_next;
    logic [15:0] countdown_reg, countdown_next;
    logic [15:0] crc_now_reg, crc_now_next;
    logic [15:0] crc_one_reg, crc_one_next;
    logic [15:0] crc_two_reg, crc_two_next;
    logic [15:0] last_two_reg, last_two_next;
    logic [8:0]  count_reg, count_next;

    logic [15:0] crc_upd;
    logic [15:0] cd_dec;
    logic [15:0] rx_crc;
    logic        good;

    // Bitwise reflected CRC-16 update over one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    assign crc_upd = crc_byte(crc_now_reg, item.rx_byte);
    assign cd_dec  = countdown_reg - 16'd1;
    // Trailing bytes: CRC low byte first, so last byte is the high half
    assign rx_crc  = {last_two_reg[7:0], last_two_reg[15:8]};
    assign good    = (count_reg >= 9'd3) && (rx_crc == crc_two_reg);

    always_comb
    begin
        mode_next      = mode_reg;
        countdown_next = countdown_reg;
        crc_now_next   = crc_now_reg;
        crc_one_next   = crc_one_reg;
        crc_two_next   = crc_two_reg;
        last_two_next  = last_two_reg;
        count_next     = count_reg;
        res            = '0;

        if (fire)
        begin
            unique case (item.func)
                FUNC_BYTE:
                begin
                    mode_next      = MODE_FRAME;
                    countdown_next = silence_ticks;
                    crc_two_next   = crc_one_reg;
                    crc_one_next   = crc_now_reg;
                    crc_now_next   = crc_upd;
                    last_two_next  = {last_two_reg[7:0], item.rx_byte};
                    if (count_reg >= COUNT_LIMIT)
                    begin
                        count_next = COUNT_LIMIT;
                        res.valid  = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + 9'd1;
                        res.valid  = (count_reg + 9'd1) >= COUNT_LIMIT;
                    end
                    res.item.event_res    = EV_OVERFLOW;
                    res.item.frame_length = count_next;
                end
                FUNC_TICK:
                begin
                    if (countdown_reg != 16'd0)
                    begin
                        countdown_next = cd_dec;
                        if (cd_dec == 16'd0)
                        begin
                            res.item.frame_length = count_reg;
                            if (mode_reg == MODE_FRAME)
                            begin
                                res.valid          = 1'b1;
                                res.item.event_res = good ? EV_GOOD : EV_BAD;
                            end
                            else if (mode_reg == MODE_ANSWER)
                            begin
                                res.valid          = 1'b1;
                                res.item.event_res = EV_TIMEOUT;
                            end
                            mode_next     = MODE_IDLE;
                            crc_now_next  = CRC_INIT;
                            crc_one_next  = CRC_INIT;
                            crc_two_next  = CRC_INIT;
                            last_two_next = '0;
                            count_next    = '0;
                        end
                    end
                end
                FUNC_SEND:
                begin
                    if (item.need_ack)
                    begin
                        mode_next      = MODE_ANSWER;
                        countdown_next = answer_ticks;
                    end
                end
                FUNC_FLUSH:
                begin
                    mode_next      = MODE_IDLE;
                    countdown_next = '0;
                    crc_now_next   = CRC_INIT;
                    crc_one_next   = CRC_INIT;
                    crc_two_next   = CRC_INIT;
                    last_two_next  = '0;
                    count_next     = '0;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            countdown_reg <= '0;
            crc_now_reg   <= CRC_INIT;
            crc_one_reg   <= CRC_INIT;
            crc_two_reg   <= CRC_INIT;
            last_two_reg  <= '0;
            count_reg     <= '0;
        end
        else
        begin
            mode_reg      <= mode_next;
            countdown_reg <= countdown_next;
            crc_now_reg   <= crc_now_next;
            crc_one_reg   <= crc_one_next;
            crc_two_reg   <= crc_two_next;
            last_two_reg  <= last_two_next;
            count_reg     <= count_next;
        end
    end

endmodule

// ===== hdl/modbus_rtu_frame_receiver.sv =====
// Top level of the Modbus RTU frame receiver: input and result registers,
// configuration registers. Depends on mbrtu_pkg and mbrtu_frame_ctl.
//
//  channel | handshake          | payload                    | beat
//  --------+--------------------+----------------------------+---------------------
//  in      | in_valid/in_ready  | in_data (in_item_t)        | byte, tick, send, flush
//  out     | out_valid/out_ready| out_data (out_item_t)      | one frame event
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data[15:0]  | one register write
//
// One beat per cycle sustained while results are taken: a beat sits in the
// input register, is processed there by the CRC/timer logic, and any event
// lands in the result register.
// While a result waits unaccepted, the held beat is not processed, whether
// or not it would raise an event, and in_ready drops until out_ready is seen.
// Reset: idle, timer zero, CRC chain 0xFFFF, count zero, silence 35, answer 1000.
module modbus_rtu_frame_receiver
    import mbrtu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg;
    logic [15:0] silence_reg;
    logic [15:0] answer_reg;

    logic        fire;
    res_t        res;

    // Process the held beat when the result register is free or draining
    assign fire      = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    mbrtu_frame_ctl u_ctl (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .item          (in_item_reg),
        .silence_ticks (silence_reg),
        .answer_ticks  (answer_reg),
        .res           (res)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_item_reg <= in_data;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire && res.valid)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && res.valid)
            out_item_reg <= res.item;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            silence_reg <= 16'd35;
            answer_reg  <= 16'd1000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SILENCE: silence_reg <= cfg_data;
                CFG_ANSWER:  answer_reg  <= cfg_data;
                default:     silence_reg <= silence_reg;
            endcase
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for modbus_rtu_frame_receiver: directed and random beats,
// checked against an in-bench CRC/timer predictor. Depends on mbrtu_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import mbrtu_pkg::*;

    // Run limits: watchdog, settle time after the last expected event,
    // and the long receiver hold-off.
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES   = 400;

    typedef enum logic [1:0]
    {
        RX_IDLE   = 2'd0,
        RX_ANSWER = 2'd1,
        RX_FRAME  = 2'd2
    } rx_mode_e;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    in_item_t    in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_SILENCE;
    logic [15:0] cfg_data  = '0;

    modbus_rtu_frame_receiver u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: register copies and the receive chain
    // ------------------------------------------------------------------
    logic [15:0] silence_reg = 16'd35;
    logic [15:0] answer_reg  = 16'd1000;
    rx_mode_e    rx_mode     = RX_IDLE;
    logic [15:0] countdown   = '0;
    logic [15:0] crc_now     = CRC_INIT;
    logic [15:0] crc_one_back = CRC_INIT;
    logic [15:0] crc_two_back = CRC_INIT;
    logic [15:0] last_two    = '0;
    logic [8:0]  byte_count  = '0;

    out_item_t   expected_events[$];   // events still owed by the block
    in_item_t    pending_items[$];     // beats not yet offered
    int unsigned items_queued   = 0;
    int unsigned items_accepted = 0;
    int unsigned mismatches     = 0;
    int unsigned cycle_count    = 0;

    // Idling knobs, percent of cycles
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // Long hold-off requests, served and counted by the monitor
    int unsigned hold_requests = 0;
    int unsigned hold_served   = 0;
    int unsigned hold_left     = 0;

    // Running CRC of the frame being built by the stimulus
    logic [15:0] frame_crc = CRC_INIT;

    function automatic logic [15:0] crc16_modbus(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        int          i;
        c = crc ^ {8'h00, b};
        for (i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic void clear_rx_state();
        rx_mode      = RX_IDLE;
        countdown    = '0;
        crc_now      = CRC_INIT;
        crc_one_back = CRC_INIT;
        crc_two_back = CRC_INIT;
        last_two     = '0;
        byte_count   = '0;
    endfunction

    // Advance the receive chain by one accepted beat; queue the event it causes.
    function automatic void predict_frame_event(input in_item_t it);
        out_item_t   ev;
        bit          emit;
        logic [15:0] rx_crc;
        logic [8:0]  n;
        emit = 1'b0;
        ev   = '0;
        case (it.func)
            FUNC_BYTE:
            begin
                // a byte always (re)opens a frame, even while waiting for an answer
                rx_mode      = RX_FRAME;
                countdown    = silence_reg;
                crc_two_back = crc_one_back;
                crc_one_back = crc_now;
                crc_now      = crc16_modbus(crc_now, it.rx_byte);
                last_two     = {last_two[7:0], it.rx_byte};
                if (byte_count < COUNT_LIMIT)
                    byte_count = byte_count + 9'd1;
                // reaching the limit and every byte at the limit flag overflow
                if (byte_count >= COUNT_LIMIT)
                begin
                    emit = 1'b1;
                    ev.event_res    = EV_OVERFLOW;
                    ev.frame_length = byte_count;
                end
            end
            FUNC_TICK:
            begin
                if (countdown != 0)
                begin
                    countdown = countdown - 16'd1;
                    if (countdown == 0)
                    begin
                        n = byte_count;
                        if (rx_mode == RX_FRAME)
                        begin
                            // trailing bytes arrive CRC low byte first
                            rx_crc = {last_two[7:0], last_two[15:8]};
                            emit = 1'b1;
                            ev.event_res = (n >= 9'd3 && rx_crc == crc_two_back) ?
                                           EV_GOOD : EV_BAD;
                            ev.frame_length = n;
                        end
                        else if (rx_mode == RX_ANSWER)
                        begin
                            emit = 1'b1;
                            ev.event_res    = EV_TIMEOUT;
                            ev.frame_length = n;
                        end
                        clear_rx_state();
                    end
                end
            end
            FUNC_SEND:
            begin
                if (it.need_ack)
                begin
                    rx_mode   = RX_ANSWER;
                    countdown = answer_reg;
                end
            end
            default:
                clear_rx_state();
        endcase
        if (emit)
            expected_events.push_back(ev);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_item(input logic [1:0] f, input logic [7:0] b, input logic a);
        in_item_t it;
        it.func     = f;
        it.rx_byte  = b;
        it.need_ack = a;
        pending_items.push_back(it);
        items_queued++;
    endfunction

    function automatic void push_ticks(input int unsigned k);
        int unsigned i;
        for (i = 0; i < k; i++)
            push_item(FUNC_TICK, 8'($urandom), 1'($urandom));
    endfunction

    function automatic void frame_byte(input logic [7:0] b);
        frame_crc = crc16_modbus(frame_crc, b);
        push_item(FUNC_BYTE, b, 1'($urandom));
    endfunction

    // Append the CRC tail, low byte first; a corrupt tail flips bits of the low byte.
    function automatic void frame_end(input bit corrupt);
        logic [15:0] c;
        c = frame_crc;
        if (corrupt)
            c[7:0] = c[7:0] ^ 8'($urandom_range(255, 1));
        push_item(FUNC_BYTE, c[7:0], 1'($urandom));
        push_item(FUNC_BYTE, c[15:8], 1'($urandom));
        frame_crc = CRC_INIT;
    endfunction

    // Mostly well-formed frames and send/answer exchanges; some flushes and noise.
    task automatic random_traffic(input int unsigned n);
        int unsigned start;
        int unsigned len;
        int unsigned pick;
        int unsigned k;
        start = items_queued;
        while (items_queued - start < n)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                len = $urandom_range(8);
                for (k = 0; k < len; k++)
                    frame_byte(8'($urandom));
                if ($urandom_range(9) != 0)
                    frame_end($urandom_range(4) == 0);
                else
                    frame_crc = CRC_INIT;
                // usually enough silence to close the frame, sometimes not
                if ($urandom_range(6) != 0)
                    push_ticks(silence_reg + $urandom_range(1));
                else
                    push_ticks($urandom_range(silence_reg));
            end
            else if (pick < 75)
            begin
                push_item(FUNC_SEND, 8'($urandom), $urandom_range(3) != 0);
                if ($urandom_range(4) == 0)
                    push_item(FUNC_BYTE, 8'($urandom), 1'($urandom));
                push_ticks($urandom_range(answer_reg + 1));
            end
            else if (pick < 83)
                push_item(FUNC_FLUSH, 8'($urandom), 1'($urandom));
            else
                push_item(2'($urandom), 8'($urandom), 1'($urandom));
        end
    endtask

    // Block is idle once every beat is in and every event is out; then let it settle.
    task automatic wait_drained();
        while (items_accepted != items_queued || expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_SILENCE)
            silence_reg = val;
        else
            answer_reg = val;
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued beats, predicts on each accepted beat
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_frame_event(in_data);
                items_accepted++;
            end
            // payload holds while a beat waits for ready
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_data  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each event beat, drives out_ready with stalls
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : event_check
        out_item_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("unexpected beat: event_res %0d frame_length %0d",
                           out_data.event_res, out_data.frame_length);
                    mismatches++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (out_data.event_res !== want.event_res)
                    begin
                        $error("event_res: expected %0d, got %0d",
                               want.event_res, out_data.event_res);
                        mismatches++;
                    end
                    if (out_data.frame_length !== want.frame_length)
                    begin
                        $error("frame_length: expected %0d, got %0d",
                               want.frame_length, out_data.frame_length);
                        mismatches++;
                    end
                end
            end
            // a long hold-off lets results back up into the input
            if (hold_requests != hold_served)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: short timers, no idling
        cfg_write(CFG_SILENCE, 16'd3);
        cfg_write(CFG_ANSWER, 16'd2);
        push_item(FUNC_TICK, 8'h00, 1'b0);     // tick with timer stopped
        push_item(FUNC_SEND, 8'hFF, 1'b0);     // send without ack: no effect
        frame_byte(8'h00);                     // good frame, byte extremes
        frame_byte(8'hFF);
        frame_end(1'b0);
        push_ticks(3);
        frame_byte(8'h5A);                     // bad CRC
        frame_end(1'b1);
        push_ticks(3);
        push_item(FUNC_BYTE, 8'hFF, 1'b1);     // two-byte frame whose tail matches
        push_item(FUNC_BYTE, 8'hFF, 1'b0);     // the empty CRC: still rejected as short
        push_ticks(3);
        push_item(FUNC_BYTE, 8'h80, 1'b0);     // answer timeout keeps the byte count
        push_item(FUNC_SEND, 8'h00, 1'b1);
        push_ticks(2);
        push_item(FUNC_BYTE, 8'h7F, 1'b0);     // byte while waiting for an answer,
        push_item(FUNC_SEND, 8'h00, 1'b1);     // then flush mid-frame
        push_item(FUNC_BYTE, 8'h01, 1'b1);
        push_item(FUNC_FLUSH, 8'hA5, 1'b1);
        wait_drained();

        // Fastest timers, sender idling
        cfg_write(CFG_SILENCE, 16'd1);
        cfg_write(CFG_ANSWER, 16'd1);
        send_idle_pct  = 66;
        recv_stall_pct = 0;
        random_traffic(90);
        wait_drained();

        // Zero silence never closes a frame; longest answer wait; receiver stalling
        cfg_write(CFG_SILENCE, 16'd0);
        cfg_write(CFG_ANSWER, 16'hFFFF);
        send_idle_pct  = 0;
        recv_stall_pct = 66;
        frame_byte(8'($urandom));
        frame_byte(8'($urandom));
        frame_end(1'b0);
        push_ticks(4);
        push_item(FUNC_SEND, 8'h00, 1'b1);
        push_ticks(3);
        push_item(FUNC_FLUSH, 8'h00, 1'b0);
        wait_drained();
        cfg_write(CFG_ANSWER, 16'd0);          // zero answer wait never times out
        push_item(FUNC_SEND, 8'h00, 1'b1);
        push_ticks(2);
        push_item(FUNC_BYTE, 8'h3C, 1'b0);
        push_item(FUNC_FLUSH, 8'h00, 1'b0);
        wait_drained();

        // Overflow under back-pressure: hold the receiver while an oversized
        // frame streams in, so overflow beats fill the result path.
        cfg_write(CFG_SILENCE, 16'hFFFF);
        cfg_write(CFG_ANSWER, 16'd1000);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests++;
        repeat (COUNT_LIMIT_INT + 4)
            push_item(FUNC_BYTE, 8'($urandom), 1'($urandom));
        push_item(FUNC_FLUSH, 8'h00, 1'b0);
        wait_drained();

        // Random phases with short timers across the idling mixes
        cfg_write(CFG_SILENCE, 16'($urandom_range(4, 2)));
        cfg_write(CFG_ANSWER, 16'($urandom_range(6, 2)));
        send_idle_pct  = 0;
        recv_stall_pct = 66;
        random_traffic(90);
        wait_drained();

        cfg_write(CFG_SILENCE, 16'd2);
        cfg_write(CFG_ANSWER, 16'd3);
        send_idle_pct  = 37;
        recv_stall_pct = 37;
        random_traffic(90);
        wait_drained();

        cfg_write(CFG_SILENCE, 16'd5);
        cfg_write(CFG_ANSWER, 16'd4);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_traffic(90);
        wait_drained();

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/mbrtu_pkg.sv
hdl/mbrtu_frame_ctl.sv
hdl/modbus_rtu_frame_receiver.sv
tb/sv/tb_top.sv
